### src/bpc_pkg.sv
// shared types, register indexes and arithmetic helpers for the baro compensation block
package bpc_pkg;

    localparam int DIV_BITS = 32;

    // configuration register indexes
    localparam logic [1:0] CFG_TEMP_CALIB    = 2'd0;
    localparam logic [1:0] CFG_PRESS_CALIB_A = 2'd1;
    localparam logic [1:0] CFG_PRESS_CALIB_B = 2'd2;
    localparam logic [1:0] CFG_PRESS_CALIB_C = 2'd3;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
    } bpc_in_t;

    typedef struct packed {
        logic signed [26:0] temperature;
        logic [31:0]        pressure;
        logic               pressure_invalid;
    } bpc_out_t;

    // data that rides alongside the divider
    typedef struct packed {
        logic [26:0] temperature;
        logic        inval;
        logic        dbl;
    } bpc_side_t;

    // arithmetic right shift of a 32-bit two's complement word
    function automatic logic [31:0] sra32(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

    // sign-extend a 16-bit calibration word
    function automatic logic [31:0] sext16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

endpackage

### src/baro_temp_pressure_compensation_top.sv
// top level of the barometric temperature and pressure compensation pipeline
//
//  channel  | ports                     | handshake     | payload
//  ---------+---------------------------+---------------+-------------------------------
//  input    | s_valid s_ready s_data    | valid/ready   | raw_temp, raw_press
//  result   | m_valid m_ready m_data    | valid/ready   | temperature, pressure, invalid
//  config   | cfg_we cfg_index cfg_wdata| write enable  | calibration words 0..3
//
// one transfer per cycle in and out unless the result is stalled; input to result runs through
// 10 front stages, 32 divider stages of one quotient bit each and 5 back stages
// the 32-stage restoring divider is the longest part of the pipeline; every stage holds one item
// reset clears the valid bits and the calibration registers
// a stalled result freezes the whole pipeline, nothing is lost or repeated
module baro_temp_pressure_compensation_top
    import bpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  bpc_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output bpc_out_t    m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    // calibration registers
    logic [47:0] temp_calib_reg;
    logic [63:0] pca_reg;
    logic [63:0] pcb_reg;
    logic [15:0] pcc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_calib_reg <= '0;
            pca_reg        <= '0;
            pcb_reg        <= '0;
            pcc_reg        <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TEMP_CALIB:    temp_calib_reg <= cfg_wdata[47:0];
                CFG_PRESS_CALIB_A: pca_reg        <= cfg_wdata;
                CFG_PRESS_CALIB_B: pcb_reg        <= cfg_wdata;
                CFG_PRESS_CALIB_C: pcc_reg        <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // calibration words
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'b0, temp_calib_reg[15:0]};
    assign t2 = sext16(temp_calib_reg[31:16]);
    assign t3 = sext16(temp_calib_reg[47:32]);
    assign p1 = {16'b0, pca_reg[15:0]};
    assign p2 = sext16(pca_reg[31:16]);
    assign p3 = sext16(pca_reg[47:32]);
    assign p4 = sext16(pca_reg[63:48]);
    assign p5 = sext16(pcb_reg[15:0]);
    assign p6 = sext16(pcb_reg[31:16]);
    assign p7 = sext16(pcb_reg[47:32]);
    assign p8 = sext16(pcb_reg[63:48]);
    assign p9 = sext16(pcc_reg);

    // global advance: the whole pipeline moves unless the result is stalled
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    logic [9:0] fv_reg;
    logic [4:0] bv_reg;
    logic       div_vld;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= '0;
            bv_reg <= '0;
        end else if (adv) begin
            fv_reg <= {fv_reg[8:0], s_valid};
            bv_reg <= {bv_reg[3:0], div_vld};
        end
    end

    // front stage payload
    logic [31:0] s1_x_reg, s1_d_reg;
    logic [31:0] s2_m1_reg, s2_dd_reg;
    logic [31:0] s3_a_reg, s3_m2_reg;
    logic [31:0] s4_tf_reg;
    logic [31:0] s5_tt_reg, s5_v1_reg;
    logic [26:0] s6_temp_reg, s7_temp_reg, s8_temp_reg, s9_temp_reg, s10_temp_reg;
    logic [31:0] s6_sq_reg, s6_m5_reg, s6_m2_reg;
    logic [31:0] s7_m6_reg, s7_m3_reg, s7_m5_reg, s7_m2_reg;
    logic [31:0] s8_v2_reg, s8_v1_reg;
    logic [31:0] s9_m1_reg, s9_x_reg;
    logic [31:0] s10_dvs_reg, s10_pm_reg;
    logic [19:0] ap_reg [8];

    always_ff @(posedge aclk) begin
        if (adv) begin
            // raw pressure rides along until it is used
            ap_reg[0] <= s_data.raw_press;
            for (int k = 1; k < 8; k++) begin
                ap_reg[k] <= ap_reg[k-1];
            end
            // fine temperature terms
            s1_x_reg  <= 32'(s_data.raw_temp[19:3]) - (t1 << 1);
            s1_d_reg  <= 32'(s_data.raw_temp[19:4]) - t1;
            s2_m1_reg <= s1_x_reg * t2;
            s2_dd_reg <= s1_d_reg * s1_d_reg;
            s3_a_reg  <= sra32(s2_m1_reg, 11);
            s3_m2_reg <= sra32(s2_dd_reg, 12) * t3;
            s4_tf_reg <= s3_a_reg + sra32(s3_m2_reg, 14);
            // temperature and first pressure variable
            s5_tt_reg <= s4_tf_reg * 32'd5 + 32'd128;
            s5_v1_reg <= sra32(s4_tf_reg, 1) - 32'd64000;
            s6_temp_reg <= 27'(sra32(s5_tt_reg, 8));
            s6_sq_reg   <= sra32(s5_v1_reg, 2) * sra32(s5_v1_reg, 2);
            s6_m5_reg   <= s5_v1_reg * p5;
            s6_m2_reg   <= p2 * s5_v1_reg;
            s7_temp_reg <= s6_temp_reg;
            s7_m6_reg   <= sra32(s6_sq_reg, 11) * p6;
            s7_m3_reg   <= p3 * sra32(s6_sq_reg, 13);
            s7_m5_reg   <= s6_m5_reg;
            s7_m2_reg   <= s6_m2_reg;
            // combine into v2 and v1
            s8_temp_reg <= s7_temp_reg;
            s8_v2_reg   <= sra32(s7_m6_reg + (s7_m5_reg << 1), 2) + (p4 << 16);
            s8_v1_reg   <= sra32(sra32(s7_m3_reg, 3) + sra32(s7_m2_reg, 1), 18);
            s9_temp_reg <= s8_temp_reg;
            s9_m1_reg   <= (32'd32768 + s8_v1_reg) * p1;
            s9_x_reg    <= (32'd1048576 - 32'(ap_reg[7])) - sra32(s8_v2_reg, 12);
            // divisor and scaled dividend
            s10_temp_reg <= s9_temp_reg;
            s10_dvs_reg  <= sra32(s9_m1_reg, 15);
            s10_pm_reg   <= s9_x_reg * 32'd3125;
        end
    end

    // divider feed: double before dividing unless the top bit is set
    bpc_side_t   div_in_side, div_out_side;
    logic [31:0] div_dividend, div_quot;

    always_comb begin
        div_in_side.temperature = s10_temp_reg;
        div_in_side.inval       = (s10_dvs_reg == '0);
        div_in_side.dbl         = s10_pm_reg[31];
        div_dividend = s10_pm_reg[31] ? s10_pm_reg : {s10_pm_reg[30:0], 1'b0};
    end

    bpc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (fv_reg[9]),
        .dividend  (div_dividend),
        .divisor   (s10_dvs_reg),
        .in_side   (div_in_side),
        .out_valid (div_vld),
        .quotient  (div_quot),
        .out_side  (div_out_side)
    );

    // back stage payload
    bpc_side_t   sa_side_reg, sb_side_reg, sc_side_reg, sd_side_reg;
    logic [31:0] sa_p_reg, sb_p_reg, sc_p_reg, sd_p_reg;
    logic [31:0] sb_qq_reg, sb_m8_reg;
    logic [31:0] sc_m9_reg, sc_m8_reg;
    logic [31:0] sd_sum_reg;
    bpc_out_t    out_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sa_side_reg <= div_out_side;
            sa_p_reg    <= div_out_side.dbl ? {div_quot[30:0], 1'b0} : div_quot;
            // correction products
            sb_side_reg <= sa_side_reg;
            sb_p_reg    <= sa_p_reg;
            sb_qq_reg   <= (sa_p_reg >> 3) * (sa_p_reg >> 3);
            sb_m8_reg   <= (sa_p_reg >> 2) * p8;
            sc_side_reg <= sb_side_reg;
            sc_p_reg    <= sb_p_reg;
            sc_m9_reg   <= p9 * (sb_qq_reg >> 13);
            sc_m8_reg   <= sb_m8_reg;
            sd_side_reg <= sc_side_reg;
            sd_p_reg    <= sc_p_reg;
            sd_sum_reg  <= sra32(sc_m9_reg, 12) + sra32(sc_m8_reg, 13) + p7;
            // result register
            out_reg.temperature      <= $signed(sd_side_reg.temperature);
            out_reg.pressure_invalid <= sd_side_reg.inval;
            out_reg.pressure         <= sd_side_reg.inval ? 32'd0
                                        : sd_p_reg + sra32(sd_sum_reg, 4);
        end
    end

    assign m_valid = bv_reg[4];
    assign m_data  = out_reg;

    // an invalid result always carries zero pressure
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.pressure_invalid) |-> (m_data.pressure == 32'd0))
        else $error("invalid pressure result is not zero");

    // the input is held off only by a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a stalled result");

    // no result straight out of reset
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // a stalled pipeline keeps the divider output in place
    assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(div_vld) && $stable(div_quot))
        else $error("divider moved during a stall");

endmodule

### src/bpc_div.sv
// pipelined restoring unsigned divider, one quotient bit per stage
module bpc_div
    import bpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    input  bpc_side_t   in_side,
    output logic        out_valid,
    output logic [31:0] quotient,
    output bpc_side_t   out_side
);

    logic [DIV_BITS-1:0] vld_reg;
    logic [31:0]         rem_reg [DIV_BITS];
    logic [31:0]         dvd_reg [DIV_BITS];
    logic [31:0]         dvs_reg [DIV_BITS];
    logic [31:0]         quo_reg [DIV_BITS];
    bpc_side_t           side_reg [DIV_BITS];

    logic [31:0] rem_next [DIV_BITS];
    logic [31:0] dvd_next [DIV_BITS];
    logic [31:0] quo_next [DIV_BITS];

    // one trial subtraction per stage
    always_comb begin
        logic [31:0] rem_in;
        logic [31:0] dvd_in;
        logic [31:0] dvs_in;
        logic [31:0] quo_in;
        logic [32:0] trial;
        logic        ge;
        for (int k = 0; k < DIV_BITS; k++) begin
            if (k == 0) begin
                rem_in = '0;
                dvd_in = dividend;
                dvs_in = divisor;
                quo_in = '0;
            end else begin
                rem_in = rem_reg[k-1];
                dvd_in = dvd_reg[k-1];
                dvs_in = dvs_reg[k-1];
                quo_in = quo_reg[k-1];
            end
            trial = {rem_in, dvd_in[31]};
            ge    = (trial >= {1'b0, dvs_in});
            rem_next[k] = ge ? 32'(trial - {1'b0, dvs_in}) : trial[31:0];
            dvd_next[k] = {dvd_in[30:0], 1'b0};
            quo_next[k] = {quo_in[30:0], ge};
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_BITS-2:0], in_valid};
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DIV_BITS; k++) begin
                rem_reg[k] <= rem_next[k];
                dvd_reg[k] <= dvd_next[k];
                quo_reg[k] <= quo_next[k];
                if (k == 0) begin
                    dvs_reg[k]  <= divisor;
                    side_reg[k] <= in_side;
                end else begin
                    dvs_reg[k]  <= dvs_reg[k-1];
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    assign out_valid = vld_reg[DIV_BITS-1];
    assign quotient  = quo_reg[DIV_BITS-1];
    assign out_side  = side_reg[DIV_BITS-1];

endmodule
